/* hdl/rce_pkg.sv */
// Shared types, constants and the Student-t table of the replication confidence estimator.
// Used by every module of the block; depends on nothing.
package rce_pkg;

	localparam int WIDE_W = 128;
	localparam int MULB_W = 64;
	localparam int MIN_SAMPLES = 5;
	localparam int T_SCALE = 60000;
	localparam int T_W = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CONF_SEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCURACY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATS = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQR,
		ST_LOAD,
		ST_NSS,
		ST_SSQ,
		ST_NN,
		ST_DEN1,
		ST_VAR,
		ST_ROOT,
		ST_TSE,
		ST_SCALE,
		ST_HSQ,
		ST_NCUBE,
		ST_NUM,
		ST_ACC2,
		ST_DEN,
		ST_QUO,
		ST_DONE
	} state_t;

	// t values in thousandths: columns 0..29 are n-2, then 40, 60, 120 and infinite dof
	localparam logic [15:0] T_MILLI [3][34] = '{
		'{16'd6314, 16'd2920, 16'd2353, 16'd2132, 16'd2015, 16'd1943, 16'd1895,
		  16'd1860, 16'd1833, 16'd1812, 16'd1796, 16'd1782, 16'd1771, 16'd1761,
		  16'd1753, 16'd1746, 16'd1740, 16'd1734, 16'd1729, 16'd1725, 16'd1721,
		  16'd1717, 16'd1714, 16'd1711, 16'd1708, 16'd1706, 16'd1703, 16'd1701,
		  16'd1699, 16'd1697, 16'd1684, 16'd1671, 16'd1658, 16'd1645},
		'{16'd12706, 16'd4303, 16'd3182, 16'd2776, 16'd2571, 16'd2447, 16'd2365,
		  16'd2306, 16'd2262, 16'd2228, 16'd2201, 16'd2179, 16'd2160, 16'd2145,
		  16'd2131, 16'd2120, 16'd2110, 16'd2101, 16'd2093, 16'd2086, 16'd2080,
		  16'd2074, 16'd2069, 16'd2064, 16'd2060, 16'd2056, 16'd2052, 16'd2048,
		  16'd2045, 16'd2042, 16'd2021, 16'd2000, 16'd1980, 16'd1960},
		'{16'd63657, 16'd9925, 16'd5841, 16'd4604, 16'd4032, 16'd3707, 16'd3499,
		  16'd3355, 16'd3250, 16'd3169, 16'd3106, 16'd3055, 16'd3012, 16'd2977,
		  16'd2947, 16'd2921, 16'd2898, 16'd2878, 16'd2861, 16'd2845, 16'd2831,
		  16'd2819, 16'd2807, 16'd2797, 16'd2787, 16'd2779, 16'd2771, 16'd2763,
		  16'd2756, 16'd2750, 16'd2704, 16'd2660, 16'd2617, 16'd2576}
	};

	// t value in units of 1/60000, linear between the wide-dof columns
	function automatic logic [T_W-1:0] t_value(input logic [1:0] row, input logic [15:0] col);
		int r;
		int c;
		int v;
		r = (row > 2'd2) ? 2 : int'(row);
		c = int'(col);
		if (c < 30)
			v = int'(T_MILLI[r][c]) * 60;
		else if (c < 40)
			v = int'(T_MILLI[r][29]) * 60
				+ (int'(T_MILLI[r][30]) - int'(T_MILLI[r][29])) * (c - 29) * 6;
		else if (c < 60)
			v = int'(T_MILLI[r][30]) * 60
				+ (int'(T_MILLI[r][31]) - int'(T_MILLI[r][30])) * (c - 39) * 3;
		else if (c < 120)
			v = int'(T_MILLI[r][31]) * 60
				+ (int'(T_MILLI[r][32]) - int'(T_MILLI[r][31])) * (c - 59);
		else
			v = int'(T_MILLI[r][33]) * 60;
		return T_W'(v);
	endfunction

endpackage

/* hdl/rce_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle, product modulo 2^128.
// Depends on rce_pkg for the datapath widths.
module rce_mul import rce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] a,
	input  logic [MULB_W-1:0] b,
	output logic              done,
	output logic [WIDE_W-1:0] p
);

	logic              busy_q;
	logic [WIDE_W-1:0] a_q;
	logic [MULB_W-1:0] b_q;
	logic [WIDE_W-1:0] p_q;

	assign done = busy_q && (b_q == '0);
	assign p = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (done)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0])
				p_q <= p_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

/* hdl/rce_div.sv */
// Restoring divider, one quotient bit per cycle, with a zero-remainder flag.
// Depends on rce_pkg for the datapath width.
module rce_div import rce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] num,
	input  logic [WIDE_W-1:0] den,
	output logic              done,
	output logic [WIDE_W-1:0] quo,
	output logic              exact
);

	localparam int CNT_W = $clog2(WIDE_W) + 1;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] sh_q;
	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] den_q;
	logic [WIDE_W:0]   trial;
	logic [WIDE_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, sh_q[WIDE_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};
	assign done = busy_q && (cnt_q == '0);
	assign quo = sh_q;
	assign exact = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(WIDE_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q && (cnt_q != '0)) begin
			// shift the next numerator bit in, the quotient bit in at the bottom
			rem_q <= fits ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
			sh_q <= {sh_q[WIDE_W-2:0], fits};
		end
	end

endmodule

/* hdl/rce_sqrt.sv */
// Digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on rce_pkg for the datapath width.
module rce_sqrt import rce_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MULB_W-1:0]   v,
	output logic                done,
	output logic [MULB_W/2-1:0] root
);

	logic              busy_q;
	logic [MULB_W-1:0] v_q;
	logic [MULB_W-1:0] res_q;
	logic [MULB_W-1:0] bit_q;
	logic [MULB_W-1:0] trial;

	assign trial = res_q + bit_q;
	assign done = busy_q && (bit_q == '0);
	assign root = res_q[MULB_W/2-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (done)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v;
			res_q <= '0;
			bit_q <= MULB_W'(1) << (MULB_W - 2);
		end else if (busy_q && (bit_q != '0)) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

/* hdl/replication_confidence_estimator_unit.sv */
// Replication confidence estimator: per-statistic running sums, t-interval and reps estimate.
// Depends on rce_pkg and the serial units rce_mul, rce_div and rce_sqrt.
//
// Usage:
//   Input words arrive on s_t*: s_tdata carries the Q12.12 sample, s_tuser the statistic
//   index, s_tlast marks the final statistic of a replication. One result word leaves on
//   m_t* per input word: half-width, reps left and, on a last word, the replication max
//   with its valid and goal-met flags in m_tuser.
//   Registers are written on cfg_*: index 0 confidence row, 1 target accuracy,
//   2 statistics in use. cfg_ready is always high; write only while the block is idle.
//   One word is processed at a time. A word for an unused statistic skips the arithmetic,
//   and one with fewer than five samples stops after the squaring pass (which runs one
//   bit of the sample magnitude per cycle); a full estimate runs eleven passes of the
//   bit-serial multiplier and three passes of the restoring divider plus 32 square-root
//   steps.
//   The next word is accepted while a finished result waits in the output register;
//   a stalled receiver only holds the block once the following result is ready.
//   Reset clears all sums, counts and the replication max and loads the register defaults.
module replication_confidence_estimator_unit import rce_pkg::*; #(
	parameter int NUM_STATS = 8,
	parameter int COUNT_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [23:0] sample_value
	input  logic [2:0]           s_tuser,   // [2:0] stat_index
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata,   // [23:0] half width, [39:24] reps, [55:40] max
	output logic [1:0]           m_tuser,   // [0] max_valid, [1] goal_met
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam int IDX_W = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
	localparam int SUM_W = 24 + COUNT_BITS;
	localparam int SQ_W = 48 + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [1:0]  conf_sel_q;
	logic [15:0] accuracy_q;
	logic [3:0]  stats_q;

	logic signed [SUM_W-1:0] sum_q [NUM_STATS];
	logic [SQ_W-1:0]         sq_q [NUM_STATS];
	logic [COUNT_BITS-1:0]   cnt_q [NUM_STATS];
	logic [15:0]             max_q;

	state_t state_q, state_d;
	logic   launch_q;
	logic   mul_state, div_state, sqrt_state, unit_state, unit_done;
	logic   mul_start, div_start, sqrt_start;
	logic   mul_done, div_done, sqrt_done;
	logic [WIDE_W-1:0]   mul_a, mul_p, div_num, div_den, div_quo;
	logic [MULB_W-1:0]   mul_b, sqrt_v;
	logic [MULB_W/2-1:0] sqrt_root;
	logic                div_exact;

	logic [2:0]              idx_q;
	logic signed [23:0]      x_q;
	logic                    last_q;
	logic [IDX_W-1:0]        slot;
	logic                    in_use;
	logic [23:0]             x_abs;
	logic [COUNT_BITS-1:0]   n_q;
	logic [SUM_W-1:0]        s_q;
	logic [SQ_W-1:0]         ss_q;
	logic [WIDE_W-1:0]       nq_q, s2_q;
	logic [MULB_W-1:0]       n2_q, den1_q, v_q;
	logic [MULB_W/2-1:0]     se_q;
	logic [T_W-1:0]          t_q;
	logic [23:0]             half_q;
	logic [15:0]             reps_q;
	logic [31:0]             aa_q;
	logic [15:0]             acc_eff;
	logic [WIDE_W-1:0]       qc;
	logic [MULB_W-1:0]       n_w;
	logic [MULB_W-1:0]       qdiff;
	logic [15:0]             reps_calc;
	logic [15:0]             new_max;
	logic                    out_free;
	logic                    out_valid_q;
	logic [55:0]             out_data_q;
	logic [1:0]              out_user_q;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;
	assign out_free = !out_valid_q || m_tready;

	assign slot = IDX_W'(idx_q);
	// decided on the incoming word while idle
	assign in_use = ({1'b0, s_tuser} < stats_q) && (int'(s_tuser) < NUM_STATS);
	assign x_abs = x_q[23] ? 24'(-x_q) : 24'(x_q);
	assign acc_eff = (accuracy_q == '0) ? 16'd1 : accuracy_q;
	assign n_w = MULB_W'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_sel_q <= 2'd1;
			accuracy_q <= 16'd819;
			stats_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CONF_SEL: conf_sel_q <= cfg_data[1:0];
				REG_ACCURACY: accuracy_q <= cfg_data;
				REG_STATS:    stats_q <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	rce_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	rce_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .exact(div_exact)
	);

	rce_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .v(sqrt_v),
		.done(sqrt_done), .root(sqrt_root)
	);

	// operand routing for the shared serial units
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_state = 1'b1;
		unique case (state_q)
			ST_SQR:   begin mul_a = WIDE_W'(x_abs);  mul_b = MULB_W'(x_abs); end
			ST_NSS:   begin mul_a = WIDE_W'(ss_q);   mul_b = n_w;            end
			ST_SSQ:   begin mul_a = WIDE_W'(s_q);    mul_b = MULB_W'(s_q);   end
			ST_NN:    begin mul_a = WIDE_W'(n_q);    mul_b = n_w;            end
			ST_DEN1:  begin mul_a = WIDE_W'(n2_q);   mul_b = n_w - 1'b1;     end
			ST_TSE:   begin mul_a = WIDE_W'(se_q);   mul_b = MULB_W'(t_q);   end
			ST_HSQ:   begin mul_a = WIDE_W'(half_q); mul_b = MULB_W'(half_q); end
			ST_NCUBE: begin mul_a = WIDE_W'(n2_q);   mul_b = n_w;            end
			ST_NUM:   begin mul_a = WIDE_W'(den1_q); mul_b = v_q;            end
			ST_ACC2:  begin mul_a = WIDE_W'(acc_eff); mul_b = MULB_W'(acc_eff); end
			ST_DEN:   begin mul_a = s2_q;            mul_b = MULB_W'(aa_q);  end
			default:  mul_state = 1'b0;
		endcase
	end

	always_comb begin
		div_num = '0;
		div_den = '0;
		div_state = 1'b1;
		unique case (state_q)
			ST_VAR: begin
				div_num = (nq_q >= s2_q) ? nq_q - s2_q : '0;
				div_den = WIDE_W'(den1_q);
			end
			ST_SCALE: begin
				div_num = WIDE_W'(v_q);
				div_den = WIDE_W'(T_SCALE);
			end
			ST_QUO: begin
				div_num = nq_q;
				div_den = s2_q;
			end
			default: div_state = 1'b0;
		endcase
	end

	assign sqrt_state = (state_q == ST_ROOT);
	assign sqrt_v = v_q;
	assign unit_state = mul_state || div_state || sqrt_state;
	assign unit_done = (mul_state && mul_done) || (div_state && div_done)
		|| (sqrt_state && sqrt_done);
	assign mul_start = mul_state && !launch_q;
	assign div_start = div_state && !launch_q;
	assign sqrt_start = sqrt_state && !launch_q;

	// reps from the rounded-up quotient
	always_comb begin
		qc = div_exact ? div_quo : div_quo + 1'b1;
		qdiff = qc[MULB_W-1:0] - n_w;
		if (qc[WIDE_W-1:MULB_W] != '0)
			reps_calc = 16'hFFFF;
		else if (qc[MULB_W-1:0] <= n_w)
			reps_calc = '0;
		else if (qdiff > MULB_W'(16'hFFFF))
			reps_calc = 16'hFFFF;
		else
			reps_calc = qdiff[15:0];
	end

	assign new_max = (reps_q > max_q) ? reps_q : max_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (s_tvalid)
					state_d = in_use ? ST_SQR : ST_DONE;
			ST_LOAD:
				state_d = (cnt_q[slot] < COUNT_BITS'(MIN_SAMPLES)) ? ST_DONE : ST_NSS;
			ST_DONE:
				if (out_free)
					state_d = ST_IDLE;
			default:
				if (unit_state && launch_q && unit_done) begin
					unique case (state_q)
						ST_SQR:   state_d = ST_LOAD;
						ST_NSS:   state_d = ST_SSQ;
						ST_SSQ:   state_d = ST_NN;
						ST_NN:    state_d = ST_DEN1;
						ST_DEN1:  state_d = ST_VAR;
						ST_VAR:   state_d = ST_ROOT;
						ST_ROOT:  state_d = ST_TSE;
						ST_TSE:   state_d = ST_SCALE;
						ST_SCALE: state_d = (s_q == '0) ? ST_DONE : ST_HSQ;
						ST_HSQ:   state_d = ST_NCUBE;
						ST_NCUBE: state_d = ST_NUM;
						ST_NUM:   state_d = ST_ACC2;
						ST_ACC2:  state_d = ST_DEN;
						ST_DEN:   state_d = ST_QUO;
						default:  state_d = ST_DONE;
					endcase
				end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (unit_state && state_d == state_q)
				launch_q <= 1'b1;
			else
				launch_q <= 1'b0;
		end
	end

	// per-statistic accumulators, folded in when the square is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STATS; i++) begin
				sum_q[i] <= '0;
				sq_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (state_q == ST_SQR && launch_q && mul_done && cnt_q[slot] < CNT_MAX) begin
			sum_q[slot] <= sum_q[slot] + SUM_W'(x_q);
			sq_q[slot] <= sq_q[slot] + SQ_W'(mul_p[47:0]);
			cnt_q[slot] <= cnt_q[slot] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			max_q <= last_q ? 16'd0 : new_max;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {last_q ? new_max : 16'd0, reps_q, half_q};
			out_user_q <= {last_q && (new_max == '0), last_q};
		end
	end

	// datapath captures: the input word while idle, the statistic on load, one per finished unit pass
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:
				if (s_tvalid) begin
					idx_q <= s_tuser;
					x_q <= s_tdata;
					last_q <= s_tlast;
					half_q <= '0;
					reps_q <= '0;
				end
			ST_LOAD: begin
				n_q <= cnt_q[slot];
				s_q <= sum_q[slot][SUM_W-1] ? SUM_W'(-sum_q[slot]) : SUM_W'(sum_q[slot]);
				ss_q <= sq_q[slot];
				if (cnt_q[slot] < COUNT_BITS'(MIN_SAMPLES))
					reps_q <= 16'(MIN_SAMPLES);
			end
			default:
				if (launch_q && unit_done) begin
					unique case (state_q)
						ST_NSS:  nq_q <= mul_p;
						ST_SSQ:  s2_q <= mul_p;
						ST_NN: begin
							n2_q <= mul_p[MULB_W-1:0];
							t_q <= t_value(conf_sel_q, 16'(n_q) - 16'd2);
						end
						ST_DEN1: den1_q <= mul_p[MULB_W-1:0];
						ST_VAR:
							v_q <= (div_quo[WIDE_W-1:MULB_W] != '0) ? '1
								: div_quo[MULB_W-1:0];
						ST_ROOT: se_q <= sqrt_root;
						ST_TSE:  v_q <= mul_p[MULB_W-1:0];
						ST_SCALE:
							half_q <= (div_quo > WIDE_W'(24'hFFFFFF)) ? 24'hFFFFFF
								: div_quo[23:0];
						ST_HSQ:   v_q <= mul_p[MULB_W-1:0];
						ST_NCUBE: den1_q <= mul_p[MULB_W-1:0];
						ST_NUM:   nq_q <= mul_p << 28;
						ST_ACC2:  aa_q <= mul_p[31:0];
						ST_DEN:   s2_q <= mul_p;
						ST_QUO:   reps_q <= reps_calc;
						default:  ;
					endcase
				end
		endcase
	end

endmodule
